### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the subrecord deframer.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a clocked property, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/sdf_pkg.sv
// Package for the subrecord stream deframer: beat types, phase codes, tag constant.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int unsigned TagW = 32;
  localparam int unsigned LenW = 32;

  // Tag that carries a size for the next subrecord instead of reporting itself.
  localparam logic [TagW-1:0] OverrideTag = 32'h5858_5858;

  typedef enum logic [3:0] {
    PH_TAG = 4'b0001,
    PH_LEN = 4'b0010,
    PH_PAY = 4'b0100,
    PH_OVR = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [TagW-1:0] sub_tag;
    logic [LenW-1:0] sub_length;
    logic [7:0]      payload_byte;
    logic            has_byte;
    logic            first_byte;
    logic            last_byte;
    logic            empty_sub;
    logic            truncated;
  } out_item_t;

endpackage

### rtl/core/subrecord_stream_deframer_top.sv
// Subrecord stream deframer, top level and only module.
// Depends on sdf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one byte of a
//   record data block per beat; block_end marks the last byte of the block.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries at most one
//   result beat per input beat: a payload byte tagged with its subrecord tag and
//   length in effect, an empty-subrecord marker, or a truncation report.
//   Header bytes and "XXXX" size overrides produce no output beat.
//   A result is loaded into the output register when its input beat is
//   accepted. Throughput: one byte per cycle while the input is not stalled,
//   set by the single registered pass (tag/length assembly, one 32-bit decrement and compare).
//   The input is stalled only while a result sits in the output register and
//   the receiver stalls it; the result register then holds its beat unchanged.
//   Reset clears the parser to the tag phase with no pending override and an
//   empty output register. Every beat flagged block_end also returns the parser
//   to that state, after reporting truncation if the block ended mid header,
//   mid payload or mid override size.
module subrecord_stream_deframer_top
  import sdf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Parser state
  phase_e          phase_q, phase_d;
  logic [1:0]      hc_q, hc_d;          // byte count within the current header field
  logic [TagW-1:0] tag_q, tag_d;
  logic [LenW-1:0] len_q, len_d;        // length in effect for the current subrecord
  logic [LenW-1:0] rem_q, rem_d;        // payload bytes still to come
  logic [LenW-1:0] ovr_q, ovr_d;        // pending size override, zero if none
  logic            inovr_q, inovr_d;    // header being read is an override header

  // Result register
  logic      out_valid_q;
  out_item_t out_q;

  out_item_t       res;
  logic            res_valid;
  logic            in_fire;
  logic [TagW-1:0] byte_word;           // incoming byte placed at its header lane
  logic [LenW-1:0] len_eff;

  // Stall only when the result register is full and the receiver holds it.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign byte_word = TagW'(in_data_i.data_byte) << {hc_q, 3'b000};

  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    tag_d     = tag_q;
    len_d     = len_q;
    rem_d     = rem_q;
    ovr_d     = ovr_q;
    inovr_d   = inovr_q;
    res       = '0;
    res_valid = 1'b0;
    len_eff   = '0;

    case (phase_q)
      PH_TAG: begin
        // Assemble the tag, first character in the low byte.
        tag_d = ((hc_q == 2'd0) ? '0 : tag_q) | byte_word;
        hc_d  = hc_q + 2'd1;
        if (hc_q == 2'd3) begin
          phase_d = PH_LEN;
          inovr_d = (tag_d == OverrideTag);
        end
      end
      PH_LEN: begin
        if (hc_q == 2'd0) begin
          len_d = LenW'(in_data_i.data_byte);
          hc_d  = 2'd1;
        end else begin
          hc_d = 2'd0;
          if (inovr_q) begin
            // Override header: its own length is ignored, four size bytes follow.
            len_d   = LenW'({in_data_i.data_byte, len_q[7:0]});
            ovr_d   = '0;
            phase_d = PH_OVR;
          end else begin
            // A nonzero pending override replaces the length, then is consumed.
            len_eff = (ovr_q != '0) ? ovr_q : LenW'({in_data_i.data_byte, len_q[7:0]});
            len_d   = len_eff;
            ovr_d   = '0;
            if (len_eff == '0) begin
              res.sub_tag   = tag_q;
              res.empty_sub = 1'b1;
              res_valid     = 1'b1;
              phase_d       = PH_TAG;
            end else begin
              rem_d   = len_eff;
              phase_d = PH_PAY;
            end
          end
        end
      end
      PH_PAY: begin
        res.sub_tag      = tag_q;
        res.sub_length   = len_q;
        res.payload_byte = in_data_i.data_byte;
        res.has_byte     = 1'b1;
        res.first_byte   = (rem_q == len_q);
        res.last_byte    = (rem_q == LenW'(1));
        res_valid        = 1'b1;
        rem_d            = rem_q - LenW'(1);
        if (rem_q == LenW'(1)) begin
          phase_d = PH_TAG;
        end
      end
      PH_OVR: begin
        ovr_d = ovr_q | byte_word;
        hc_d  = hc_q + 2'd1;
        if (hc_q == 2'd3) begin
          phase_d = PH_TAG;
          inovr_d = 1'b0;
        end
      end
      default: begin
        phase_d = PH_TAG;
        hc_d    = 2'd0;
      end
    endcase

    if (in_data_i.block_end) begin
      // Report truncation unless the block ended on a subrecord boundary.
      if (!(phase_d == PH_TAG && hc_d == 2'd0)) begin
        res           = '0;
        res.truncated = 1'b1;
        res_valid     = 1'b1;
      end
      phase_d = PH_TAG;
      hc_d    = 2'd0;
      tag_d   = '0;
      len_d   = '0;
      rem_d   = '0;
      ovr_d   = '0;
      inovr_d = 1'b0;
    end
  end

  // Advance the parser on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      hc_q    <= 2'd0;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      ovr_q   <= '0;
      inovr_q <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      ovr_q   <= ovr_d;
      inovr_q <= inovr_d;
    end
  end

  // Result register: load on accept, drop once the receiver takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  `ASSERT_NEVER(a_pay_rem_nonzero, clk_i, rst_ni, phase_q == PH_PAY && rem_q == '0, "payload phase with nothing remaining")
  `ASSERT_CLK(a_trunc_alone, clk_i, rst_ni, out_valid_q && out_q.truncated |-> !out_q.has_byte && out_q.sub_tag == '0, "truncation beat carries data")
  `ASSERT_CLK(a_end_clears, clk_i, rst_ni, in_fire && in_data_i.block_end |=> phase_q == PH_TAG && hc_q == 2'd0 && ovr_q == '0 && !inovr_q, "block end did not clear parser")
  `ASSERT_CLK(a_marks_need_byte, clk_i, rst_ni, out_valid_q && (out_q.first_byte || out_q.last_byte) |-> out_q.has_byte, "first/last mark without byte")
  `ASSERT_CLK(a_ovr_phase, clk_i, rst_ni, inovr_q |-> phase_q == PH_LEN || phase_q == PH_OVR, "override flag outside override header")

endmodule
